// File: sv/lmfs_pkg.sv
// Shared types and constants for the LED matrix frame and scan driver.
// Depends on nothing; used by lmfs_frame and led_matrix_frame_scan_driver.
package lmfs_pkg;

    // Matrix edge length in pixels (columns and rows)
    localparam int C_SIZE     = 8;
    localparam int C_IDX_W    = $clog2(C_SIZE);
    // Offset of the latch pulse inside one column's group of events
    localparam int C_LATCH_OFF = C_SIZE + 1;
    localparam int C_OFF_W    = $clog2(C_LATCH_OFF + 1);

    // Operation carried by one input transaction
    typedef enum logic [2:0] {
        K_TICK      = 3'd0,
        K_SET       = 3'd1,
        K_CLR       = 3'd2,
        K_CLEAR_ALL = 3'd3,
        K_LINE      = 3'd4,
        K_REFRESH   = 3'd5
    } t_kind;

    // Serial pin that a result event drives
    typedef enum logic [1:0] {
        CH_COL   = 2'd0,
        CH_ROW   = 2'd1,
        CH_LATCH = 2'd2
    } t_chan;

    // Refresh sequencer phases
    typedef enum logic [1:0] {
        SC_IDLE = 2'd0,
        SC_HEAD = 2'd1,
        SC_BODY = 2'd2
    } t_scan_state;

    // Frame update request handed to the frame store
    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [3:0] x;
        logic [3:0] y;
        logic [3:0] end_x;
        logic [3:0] end_y;
    } t_frame_cmd;

endpackage

// File: sv/lmfs_frame.sv
// Frame store of one byte per column with pixel, clear and line updates.
// Depends on lmfs_pkg for sizes and the frame command struct.
module lmfs_frame (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lmfs_pkg::t_frame_cmd         i_cmd,
    input  logic [lmfs_pkg::C_IDX_W-1:0] i_rd_col,
    output logic [lmfs_pkg::C_SIZE-1:0]  o_rd_data
);

    logic [lmfs_pkg::C_SIZE-1:0] r_frame [lmfs_pkg::C_SIZE];
    logic [lmfs_pkg::C_SIZE-1:0] n_frame [lmfs_pkg::C_SIZE];
    logic [lmfs_pkg::C_SIZE-1:0] line_mask [lmfs_pkg::C_SIZE];
    logic                        pix_ok;
    logic [lmfs_pkg::C_IDX_W-1:0] pix_col;
    logic [lmfs_pkg::C_IDX_W-1:0] pix_row;

    // Read port for the scan sequencer
    assign o_rd_data = r_frame[i_rd_col];

    // Locate a single pixel; coordinates outside 1..size are dropped
    assign pix_ok  = (i_cmd.x >= 4'd1) && (i_cmd.x <= 4'(lmfs_pkg::C_SIZE)) &&
                     (i_cmd.y >= 4'd1) && (i_cmd.y <= 4'(lmfs_pkg::C_SIZE));
    assign pix_col = lmfs_pkg::C_IDX_W'(4'(lmfs_pkg::C_SIZE) - i_cmd.x);
    assign pix_row = lmfs_pkg::C_IDX_W'(i_cmd.y - 4'd1);

    // Build the line mask: each cell tested on its own against the segment
    always_comb begin
        logic signed [5:0] x0, y0, x1, y1, dx, dy, ax, ay;
        logic signed [5:0] xmin, xmax, ymin, ymax, px, py;
        logic              horiz, vert, diag, same_dir, xin, yin, hit;
        x0 = signed'({2'b00, i_cmd.x});
        y0 = signed'({2'b00, i_cmd.y});
        x1 = signed'({2'b00, i_cmd.end_x});
        y1 = signed'({2'b00, i_cmd.end_y});
        dx = x1 - x0;
        dy = y1 - y0;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        horiz = (dy == 6'sd0);
        vert  = (dx == 6'sd0);
        diag  = (ax == ay);
        same_dir = ((dx < 0) == (dy < 0));
        xmin = (x0 < x1) ? x0 : x1;
        xmax = (x0 < x1) ? x1 : x0;
        ymin = (y0 < y1) ? y0 : y1;
        ymax = (y0 < y1) ? y1 : y0;
        for (int c = 0; c < lmfs_pkg::C_SIZE; c++) begin
            for (int r = 0; r < lmfs_pkg::C_SIZE; r++) begin
                px  = 6'(lmfs_pkg::C_SIZE - c);
                py  = 6'(r + 1);
                xin = (px >= xmin) && (px <= xmax);
                yin = (py >= ymin) && (py <= ymax);
                if (horiz) begin
                    hit = (py == y0) && xin;
                end else if (vert) begin
                    hit = (px == x0) && yin;
                end else if (diag) begin
                    hit = xin && (same_dir ? ((py - y0) == (px - x0))
                                           : ((py - y0) == (x0 - px)));
                end else begin
                    hit = 1'b0;
                end
                line_mask[c][r] = hit;
            end
        end
    end

    // Apply the requested update
    always_comb begin
        n_frame = r_frame;
        if (i_cmd.valid) begin
            case (i_cmd.kind)
                lmfs_pkg::K_SET: begin
                    if (pix_ok) begin
                        n_frame[pix_col][pix_row] = 1'b1;
                    end
                end
                lmfs_pkg::K_CLR: begin
                    if (pix_ok) begin
                        n_frame[pix_col][pix_row] = 1'b0;
                    end
                end
                lmfs_pkg::K_CLEAR_ALL: begin
                    for (int c = 0; c < lmfs_pkg::C_SIZE; c++) begin
                        n_frame[c] = '0;
                    end
                end
                lmfs_pkg::K_LINE: begin
                    for (int c = 0; c < lmfs_pkg::C_SIZE; c++) begin
                        n_frame[c] = r_frame[c] | line_mask[c];
                    end
                end
                default: ;
            endcase
        end
    end

    // Hold the frame; reset blanks it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < lmfs_pkg::C_SIZE; c++) begin
                r_frame[c] <= '0;
            end
        end else begin
            r_frame <= n_frame;
        end
    end

endmodule

// File: sv/led_matrix_frame_scan_driver.sv
// Top level of the LED matrix frame store and serial refresh sequencer.
// Depends on lmfs_pkg and instantiates lmfs_frame.
//
// Usage:
//   A command transaction is taken at a rising edge with start high and busy
//   low. busy stays low: a new command can be issued in every cycle.
//   Commands: tick, set pixel, clear pixel, clear frame, draw line, refresh.
//   A refresh arms the sequencer; each later tick produces one serial pin
//   event on o_channel / o_bit_value, flagged by o_strobe for one cycle.
//   o_last marks the final latch of a refresh (87 events in all).
//   An event passes through the input register and then the result register,
//   which drives the pins; throughput is one command per cycle, set by the
//   single combinational pass between those registers.
//   Commands that update the frame or a tick while idle produce no event.
//   Reset blanks the frame, stops any refresh and clears the strobe.
//   The receiver cannot stall: each event is shown for exactly one cycle.
//
module led_matrix_frame_scan_driver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_kind,
    input  logic [3:0] i_x,
    input  logic [3:0] i_y,
    input  logic [3:0] i_end_x,
    input  logic [3:0] i_end_y,
    output logic       o_strobe,
    output logic [1:0] o_channel,
    output logic       o_bit_value,
    output logic       o_last
);

    localparam int IW = lmfs_pkg::C_IDX_W;
    localparam int OW = lmfs_pkg::C_OFF_W;

    // Input register
    logic                  r_in_valid;
    lmfs_pkg::t_kind       r_kind;
    logic [3:0]            r_x, r_y, r_end_x, r_end_y;

    // Sequencer state
    lmfs_pkg::t_scan_state r_state, n_state;
    logic [OW-1:0]         r_idx, n_idx;
    logic [IW-1:0]         r_col, n_col;

    // Result register
    logic                  r_out_valid, n_out_valid;
    lmfs_pkg::t_chan       r_channel, n_channel;
    logic                  r_bit, n_bit;
    logic                  r_last, n_last;

    logic                  tick;
    logic                  refresh;
    logic                  col_end;
    lmfs_pkg::t_frame_cmd  frame_cmd;
    logic [lmfs_pkg::C_SIZE-1:0] col_data;

    assign busy = 1'b0;

    // Capture each command transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= lmfs_pkg::t_kind'(i_kind);
        r_x     <= i_x;
        r_y     <= i_y;
        r_end_x <= i_end_x;
        r_end_y <= i_end_y;
    end

    // Decode the registered command; unused kinds behave as a tick
    assign refresh = r_in_valid && (r_kind == lmfs_pkg::K_REFRESH);
    assign tick    = r_in_valid && !(r_kind == lmfs_pkg::K_SET ||
                                     r_kind == lmfs_pkg::K_CLR ||
                                     r_kind == lmfs_pkg::K_CLEAR_ALL ||
                                     r_kind == lmfs_pkg::K_LINE ||
                                     r_kind == lmfs_pkg::K_REFRESH);
    assign col_end = (r_col == IW'(lmfs_pkg::C_SIZE - 1));

    assign frame_cmd.valid = r_in_valid;
    assign frame_cmd.kind  = r_kind;
    assign frame_cmd.x     = r_x;
    assign frame_cmd.y     = r_y;
    assign frame_cmd.end_x = r_end_x;
    assign frame_cmd.end_y = r_end_y;

    lmfs_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (frame_cmd),
        .i_rd_col  (r_col),
        .o_rd_data (col_data)
    );

    // Sequencer next state and counters
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_col   = r_col;
        if (refresh) begin
            n_state = lmfs_pkg::SC_HEAD;
            n_idx   = '0;
            n_col   = '0;
        end else if (tick) begin
            case (r_state)
                lmfs_pkg::SC_HEAD: begin
                    if (r_idx == OW'(lmfs_pkg::C_SIZE - 1)) begin
                        // first column has no leading shift
                        n_state = lmfs_pkg::SC_BODY;
                        n_idx   = OW'(1);
                        n_col   = '0;
                    end else begin
                        n_idx = r_idx + OW'(1);
                    end
                end
                lmfs_pkg::SC_BODY: begin
                    if (r_idx == OW'(lmfs_pkg::C_LATCH_OFF)) begin
                        if (col_end) begin
                            n_state = lmfs_pkg::SC_IDLE;
                            n_idx   = '0;
                            n_col   = '0;
                        end else begin
                            n_idx = '0;
                            n_col = r_col + IW'(1);
                        end
                    end else begin
                        n_idx = r_idx + OW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Sequencer outputs: one pin event per tick while refreshing
    always_comb begin
        n_out_valid = 1'b0;
        n_channel   = lmfs_pkg::CH_COL;
        n_bit       = 1'b0;
        n_last      = 1'b0;
        if (tick) begin
            case (r_state)
                lmfs_pkg::SC_HEAD: begin
                    n_out_valid = 1'b1;
                    n_bit       = (r_idx == OW'(lmfs_pkg::C_SIZE - 1));
                end
                lmfs_pkg::SC_BODY: begin
                    n_out_valid = 1'b1;
                    if (r_idx == '0) begin
                        n_channel = lmfs_pkg::CH_COL;
                    end else if (r_idx == OW'(lmfs_pkg::C_LATCH_OFF)) begin
                        n_channel = lmfs_pkg::CH_LATCH;
                        n_last    = col_end;
                    end else begin
                        // row bits go out inverted, MSB first
                        n_channel = lmfs_pkg::CH_ROW;
                        n_bit     = !col_data[IW'(OW'(lmfs_pkg::C_SIZE) - r_idx)];
                    end
                end
                default: ;
            endcase
        end
    end

    // Advance the sequencer and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lmfs_pkg::SC_IDLE;
            r_idx       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_channel <= n_channel;
        r_bit     <= n_bit;
        r_last    <= n_last;
    end

    assign o_strobe    = r_out_valid;
    assign o_channel   = r_channel;
    assign o_bit_value = r_bit;
    assign o_last      = r_out_valid && r_last;

`ifndef NO_ASSERTIONS
    // An event only follows a registered command while a refresh was running
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_in_valid) && ($past(r_state) != lmfs_pkg::SC_IDLE))
        else $error("event without a running refresh");

    // The final event is a latch pulse with a low data pin
    a_last_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_channel == lmfs_pkg::CH_LATCH) && !o_bit_value)
        else $error("last flag on a non-latch event");

    // The final latch leaves the sequencer idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (r_state == lmfs_pkg::SC_IDLE))
        else $error("sequencer still running after the final latch");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for led_matrix_frame_scan_driver: random command transactions
// against a frame and scan predictor. Depends on lmfs_pkg and the driver RTL.
module tb;

    // Kinds outside the enum behave as ticks
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;
    localparam int C_SIZE     = lmfs_pkg::C_SIZE;
    // Events in one full refresh: column select, per-column groups, inter-column shifts
    localparam int SCAN_LEN   = C_SIZE + C_SIZE * (C_SIZE + 1) + (C_SIZE - 1);
    localparam int ITEM_GOAL  = 1150;
    localparam int DRAIN_CYC  = 8;
    localparam int CYCLE_LIMIT = 200000;
    // Window of issued transactions with no idle cycles
    localparam int CALM_FROM  = 300;
    localparam int CALM_TO    = 600;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] x;
        logic [3:0] y;
        logic [3:0] end_x;
        logic [3:0] end_y;
    } t_matrix_cmd;

    typedef struct packed {
        lmfs_pkg::t_chan channel;
        logic            bit_value;
        logic            last;
    } t_pin_event;

    logic       i_clk;
    logic       i_rst_n  = 1'b0;
    logic       start    = 1'b0;
    logic       busy;
    logic [2:0] i_kind   = '0;
    logic [3:0] i_x      = '0;
    logic [3:0] i_y      = '0;
    logic [3:0] i_end_x  = '0;
    logic [3:0] i_end_y  = '0;
    logic       o_strobe;
    logic [1:0] o_channel;
    logic       o_bit_value;
    logic       o_last;

    t_matrix_cmd cmd_q[$];
    t_pin_event  pin_event_q[$];
    logic [7:0]  frame_shadow [C_SIZE];
    int          scan_pos;
    logic        scan_armed;
    logic        taken      = 1'b0;
    int          issued_cnt = 0;
    int          fail_cnt   = 0;
    int          cycle_cnt  = 0;

    led_matrix_frame_scan_driver u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_x         (i_x),
        .i_y         (i_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_strobe    (o_strobe),
        .o_channel   (o_channel),
        .o_bit_value (o_bit_value),
        .o_last      (o_last)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Set or clear one pixel of the shadow frame; drop off-matrix points
    function automatic void plot_pixel(int px, int py, logic on);
        if (px >= 1 && px <= C_SIZE && py >= 1 && py <= C_SIZE) begin
            frame_shadow[C_SIZE - px][py - 1] = on;
        end
    endfunction

    // Draw only straight or 45-degree lines, stepping each axis toward its end
    function automatic void draw_shadow_line(int x0, int y0, int x1, int y1);
        int dx, dy, ax, ay, sx, sy, n;
        dx = x1 - x0;
        dy = y1 - y0;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        sx = (dx < 0) ? -1 : ((dx > 0) ? 1 : 0);
        sy = (dy < 0) ? -1 : ((dy > 0) ? 1 : 0);
        if (dx == 0 || dy == 0 || ax == ay) begin
            n = (ax > ay) ? ax : ay;
            for (int i = 0; i <= n; i++) begin
                plot_pixel(x0 + sx * i, y0 + sy * i, 1'b1);
            end
        end
    endfunction

    // Apply one accepted transaction; return the pin event it causes, if any
    task automatic scan_model(input t_matrix_cmd c, output logic fires, output t_pin_event ev);
        int v, col, off;
        fires = 1'b0;
        ev    = '{channel: lmfs_pkg::CH_COL, bit_value: 1'b0, last: 1'b0};
        case (c.kind)
            lmfs_pkg::K_SET:       plot_pixel(c.x, c.y, 1'b1);
            lmfs_pkg::K_CLR:       plot_pixel(c.x, c.y, 1'b0);
            lmfs_pkg::K_CLEAR_ALL: for (int i = 0; i < C_SIZE; i++) frame_shadow[i] = '0;
            lmfs_pkg::K_LINE:      draw_shadow_line(c.x, c.y, c.end_x, c.end_y);
            lmfs_pkg::K_REFRESH: begin
                scan_armed = 1'b1;
                scan_pos   = 0;
            end
            default: begin
                if (scan_armed) begin
                    fires = 1'b1;
                    if (scan_pos < C_SIZE) begin
                        ev.bit_value = (scan_pos == C_SIZE - 1);
                    end else begin
                        // first column has no leading shift: count as if it had one
                        v   = scan_pos - C_SIZE + 1;
                        col = v / (C_SIZE + 2);
                        off = v % (C_SIZE + 2);
                        if (col >= C_SIZE) col = C_SIZE - 1;
                        if (off == 0) begin
                            ev.channel = lmfs_pkg::CH_COL;
                        end else if (off <= C_SIZE) begin
                            ev.channel   = lmfs_pkg::CH_ROW;
                            ev.bit_value = ~frame_shadow[col][C_SIZE - off];
                        end else begin
                            ev.channel = lmfs_pkg::CH_LATCH;
                            ev.last    = (col == C_SIZE - 1);
                        end
                    end
                    scan_pos++;
                    if (scan_pos >= SCAN_LEN) begin
                        scan_pos   = 0;
                        scan_armed = 1'b0;
                    end
                end
            end
        endcase
    endtask

    function automatic void add_cmd(logic [2:0] k, int x, int y, int ex, int ey);
        t_matrix_cmd c;
        c.kind  = k;
        c.x     = x[3:0];
        c.y     = y[3:0];
        c.end_x = ex[3:0];
        c.end_y = ey[3:0];
        cmd_q.push_back(c);
    endfunction

    // Coordinate mostly on the matrix, now and then anywhere in the field
    function automatic int pick_coord(bit wide);
        return wide ? $urandom_range(0, 15) : $urandom_range(1, C_SIZE);
    endfunction

    function automatic logic [2:0] pick_tick_kind();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return KIND_SPARE_A;
        if (r == 1) return KIND_SPARE_B;
        return lmfs_pkg::K_TICK;
    endfunction

    // Random frame update, lines biased toward drawable shapes
    function automatic void add_frame_update();
        int r, x0, y0, x1, y1, d;
        bit wide;
        wide = ($urandom_range(0, 9) == 0);
        x0   = pick_coord(wide);
        y0   = pick_coord(wide);
        r    = $urandom_range(0, 9);
        if (r <= 3) begin
            add_cmd(lmfs_pkg::K_SET, x0, y0, $urandom_range(0, 15), $urandom_range(0, 15));
        end else if (r <= 5) begin
            add_cmd(lmfs_pkg::K_CLR, x0, y0, $urandom_range(0, 15), $urandom_range(0, 15));
        end else if (r <= 8) begin
            x1 = pick_coord(wide);
            y1 = pick_coord(wide);
            case ($urandom_range(0, 3))
                0: y1 = y0;
                1: x1 = x0;
                2: begin
                    d  = $urandom_range(0, C_SIZE - 1);
                    x1 = $urandom_range(0, 1) ? x0 + d : x0 - d;
                    y1 = $urandom_range(0, 1) ? y0 + d : y0 - d;
                    if (x1 < 0 || x1 > 15) x1 = 2 * x0 - x1;
                    if (y1 < 0 || y1 > 15) y1 = 2 * y0 - y1;
                end
                default: ;
            endcase
            add_cmd(lmfs_pkg::K_LINE, x0, y0, x1, y1);
        end else begin
            add_cmd(lmfs_pkg::K_CLEAR_ALL, x0, y0, $urandom_range(0, 15),
                    $urandom_range(0, 15));
        end
    endfunction

    // Stimulus: directed corner cases, then refresh sequences mixed with noise
    initial begin : stimulus
        int counted, ticks, burst, k;
        for (int i = 0; i < C_SIZE; i++) frame_shadow[i] = '0;
        scan_pos   = 0;
        scan_armed = 1'b0;

        // ticks while idle, spare kinds included
        add_cmd(lmfs_pkg::K_TICK, 15, 15, 15, 15);
        add_cmd(KIND_SPARE_A, 0, 0, 0, 0);
        add_cmd(KIND_SPARE_B, 5, 10, 3, 12);
        // corner pixels, off-matrix sets, then an on-matrix and an off-matrix clear
        add_cmd(lmfs_pkg::K_SET, 1, 1, 0, 0);
        add_cmd(lmfs_pkg::K_SET, 8, 8, 0, 0);
        add_cmd(lmfs_pkg::K_SET, 8, 1, 0, 0);
        add_cmd(lmfs_pkg::K_SET, 1, 8, 0, 0);
        add_cmd(lmfs_pkg::K_SET, 0, 4, 0, 0);
        add_cmd(lmfs_pkg::K_SET, 9, 4, 0, 0);
        add_cmd(lmfs_pkg::K_SET, 4, 15, 0, 0);
        add_cmd(lmfs_pkg::K_CLR, 8, 8, 0, 0);
        add_cmd(lmfs_pkg::K_CLR, 0, 0, 0, 0);
        // lines: reversed horizontal, reversed vertical, both diagonals,
        // a skewed one that draws nothing, a single point, a clipped diagonal
        add_cmd(lmfs_pkg::K_LINE, 8, 2, 1, 2);
        add_cmd(lmfs_pkg::K_LINE, 3, 8, 3, 1);
        add_cmd(lmfs_pkg::K_LINE, 8, 8, 1, 1);
        add_cmd(lmfs_pkg::K_LINE, 7, 1, 2, 6);
        add_cmd(lmfs_pkg::K_LINE, 1, 1, 3, 8);
        add_cmd(lmfs_pkg::K_LINE, 5, 5, 5, 5);
        add_cmd(lmfs_pkg::K_LINE, 0, 15, 15, 0);
        // refresh, update the frame mid-scan, restart, then blank
        add_cmd(lmfs_pkg::K_REFRESH, 0, 0, 0, 0);
        add_cmd(lmfs_pkg::K_TICK, 0, 0, 0, 0);
        add_cmd(lmfs_pkg::K_TICK, 0, 0, 0, 0);
        add_cmd(lmfs_pkg::K_SET, 2, 3, 0, 0);
        add_cmd(lmfs_pkg::K_REFRESH, 0, 0, 0, 0);
        add_cmd(lmfs_pkg::K_CLEAR_ALL, 0, 0, 0, 0);

        counted = cmd_q.size();
        while (counted < ITEM_GOAL) begin
            if ($urandom_range(0, 99) < 70) begin
                // one refresh with random frame traffic, sometimes cut short
                add_cmd(lmfs_pkg::K_REFRESH, $urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom_range(0, 15), $urandom_range(0, 15));
                counted++;
                ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(1, SCAN_LEN - 1)
                                                     : SCAN_LEN;
                for (int i = 0; i < ticks; i++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        add_frame_update();
                        counted++;
                    end
                    add_cmd(pick_tick_kind(), $urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom_range(0, 15));
                    counted++;
                end
                if ($urandom_range(0, 3) == 0) begin
                    add_cmd(lmfs_pkg::K_TICK, $urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom_range(0, 15));
                    counted++;
                end
            end else begin
                // noise: any kind, any coordinate
                burst = $urandom_range(1, 6);
                for (int i = 0; i < burst; i++) begin
                    k = $urandom_range(0, 7);
                    add_cmd(k[2:0], $urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom_range(0, 15));
                    counted++;
                end
            end
        end

        // hold reset, release on a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every transaction to go in, every event to come out, then drain
        while (cmd_q.size() != 0 || start) @(posedge i_clk);
        while (pin_event_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Driver: present the next transaction on the falling edge, hold while refused
    always @(negedge i_clk) begin : drive_cmds
        t_matrix_cmd nxt;
        bit calm;
        if (i_rst_n && (!start || taken)) begin
            calm = (issued_cnt >= CALM_FROM && issued_cnt < CALM_TO);
            if (cmd_q.size() != 0 && (calm || $urandom_range(0, 99) >= 13)) begin
                nxt = cmd_q.pop_front();
                issued_cnt++;
                start   <= 1'b1;
                i_kind  <= nxt.kind;
                i_x     <= nxt.x;
                i_y     <= nxt.y;
                i_end_x <= nxt.end_x;
                i_end_y <= nxt.end_y;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check events first, then predict from the transaction taken at this edge
    always @(posedge i_clk) begin : watch_pins
        t_matrix_cmd c;
        t_pin_event  want, ev;
        logic        fires;
        taken = 1'b0;
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                if (pin_event_q.size() == 0) begin
                    $error("unexpected pin event: channel %0d bit %0d last %0d",
                           o_channel, o_bit_value, o_last);
                    fail_cnt++;
                end else begin
                    want = pin_event_q.pop_front();
                    if (o_channel !== want.channel) begin
                        $error("channel: expected %0d, got %0d", want.channel, o_channel);
                        fail_cnt++;
                    end
                    if (o_bit_value !== want.bit_value) begin
                        $error("bit_value: expected %0d, got %0d", want.bit_value, o_bit_value);
                        fail_cnt++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last);
                        fail_cnt++;
                    end
                end
            end
            if (start && busy === 1'b0) begin
                taken = 1'b1;
                c = '{kind: i_kind, x: i_x, y: i_y, end_x: i_end_x, end_y: i_end_y};
                scan_model(c, fires, ev);
                if (fires) pin_event_q.push_back(ev);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
